// File: rtl/pbm_pkg.sv
// Shared types, constants and helpers for the pixel blender.
`default_nettype none

package pbm_pkg;

  localparam int NumLanes = 4;
  localparam int ChW      = 8;
  localparam int FacW     = 9;
  localparam int CntW     = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  localparam logic [FacW-1:0] FacOne   = 9'd256;
  localparam logic [15:0]     DivRecip = 16'h8081;   // ceil(2^23 / 255)
  localparam logic [23:0]     HalfDen  = 24'd32640;  // 255 * 256 / 2
  localparam logic [15:0]     FullSq   = 16'd65025;  // 255 * 255
  localparam logic [CntW-1:0] MaxCnt   = 3'd4;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_MUL    = 2'd2,
    MODE_SCREEN = 2'd3
  } pbm_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FACTOR    = 2'd0,
    CFG_MODE      = 2'd1,
    CFG_FIRST_CH  = 2'd2,
    CFG_SECOND_CH = 2'd3
  } pbm_cfg_e;

  typedef struct packed {
    logic            en1;
    logic            en2;
    logic [FacW-1:0] fs;
    logic [FacW-1:0] kf;
    pbm_mode_e       mode;
  } pbm_lane_ctl_t;

  function automatic logic [CntW-1:0] clamp_cnt(input logic [CntW-1:0] n);
    logic [CntW-1:0] r;
    r = n;
    if (n == '0) begin
      r = 3'd1;
    end else if (n > MaxCnt) begin
      r = MaxCnt;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pbm_lane.sv
// One channel lane: two product stages, then divide-by-255 on the way out.
`default_nettype none

module pbm_lane
  import pbm_pkg::*;
(
  input  wire logic          clk_i,
  input  wire pbm_lane_ctl_t ctl_i,
  input  wire logic [7:0]    a_i,
  input  wire logic [7:0]    b_i,
  output logic [7:0]         res_o
);

  logic [16:0] akf_full, bf_full;
  logic [15:0] ab_full, inv_full;
  logic [15:0] akf_q, bf_q, ab_q, scr_q;
  logic [7:0]  a_q;

  assign akf_full = a_i * ctl_i.kf;
  assign bf_full  = b_i * ctl_i.fs;
  assign ab_full  = a_i * b_i;
  assign inv_full = (8'd255 - a_i) * (8'd255 - b_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      akf_q <= akf_full[15:0];
      bf_q  <= bf_full[15:0];
      ab_q  <= ab_full;
      scr_q <= FullSq - inv_full;
      a_q   <= a_i;
    end
  end

  logic [16:0] sum_n, sum_a;
  logic [15:0] mop;
  logic [24:0] mprod;
  logic [23:0] x255, num;
  logic [7:0]  direct_d;
  logic        div_d;

  always_comb begin
    sum_n = {1'b0, akf_q} + {1'b0, bf_q} + 17'd128;
    sum_a = {1'b0, a_q, 8'd0} + {1'b0, bf_q} + 17'd128;
    mop   = (ctl_i.mode == MODE_MUL) ? ab_q : scr_q;
    mprod = mop * ctl_i.fs;
    x255  = {akf_q, 8'd0} - {8'd0, akf_q};
    num   = x255 + mprod[23:0] + HalfDen;
    div_d = (ctl_i.mode == MODE_MUL) || (ctl_i.mode == MODE_SCREEN);
    case (ctl_i.mode)
      MODE_ADD: direct_d = sum_a[16] ? 8'hFF : sum_a[15:8];
      default:  direct_d = sum_n[15:8];
    endcase
  end

  logic [15:0] y_q;
  logic [7:0]  direct_q;
  logic        div_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      y_q      <= num[23:8];
      direct_q <= direct_d;
      div_q    <= div_d;
    end
  end

  logic [31:0] qprod;
  assign qprod = y_q * DivRecip;
  assign res_o = div_q ? qprod[30:23] : direct_q;

endmodule

`default_nettype wire

// File: rtl/pbm_merge.sv
// Output stage: gathers lane results, zeroes unused channels, holds the beat.
`default_nettype none

module pbm_merge
  import pbm_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [CntW-1:0]              nout_i,
  input  wire logic [NumLanes-1:0][ChW-1:0] res_i,
  output logic                              valid_o,
  output logic [NumLanes-1:0][ChW-1:0]      data_o
);

  logic                         valid_q;
  logic [NumLanes-1:0][ChW-1:0] data_q, data_d;

  always_comb begin
    for (int c = 0; c < NumLanes; c++) begin
      data_d[c] = (CntW'(c) < nout_i) ? res_i[c] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/pixel_blend_modes.sv
// Pixel blender: normal, add, multiply and screen modes over up to four channels.
//
// Input channel: in_valid_i / in_stall_o with a_ch*_i and b_ch*_i, one pixel
// pair per beat. Output channel: out_valid_o / out_stall_i with out_ch*_o.
// A beat moves when valid is high and stall is low.
// Config port: cfg_we_i, cfg_idx_i, cfg_data_i, to be written only while idle;
// the user is bound to that, as the block itself does not enforce it.
// Throughput: one pixel per clock when unstalled; four lanes, one per channel,
// each a three-stage pipe (products, weighted sum, reciprocal divide by 255).
// Stalls: each stage advances when the next is empty or moving, so bubbles
// are squeezed out; in_stall_o rises only when all three stages hold a pixel
// and the output is stalled. The output beat holds steady while stalled.
// Reset: pipeline empties, factor 128, mode normal, both channel counts 4.
`default_nettype none

module pixel_blend_modes
  import pbm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          a_ch0_i,
  input  wire logic [7:0]          a_ch1_i,
  input  wire logic [7:0]          a_ch2_i,
  input  wire logic [7:0]          a_ch3_i,
  input  wire logic [7:0]          b_ch0_i,
  input  wire logic [7:0]          b_ch1_i,
  input  wire logic [7:0]          b_ch2_i,
  input  wire logic [7:0]          b_ch3_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               out_ch0_o,
  output logic [7:0]               out_ch1_o,
  output logic [7:0]               out_ch2_o,
  output logic [7:0]               out_ch3_o
);

  logic [FacW-1:0] factor_q;
  pbm_mode_e       mode_q;
  logic [CntW-1:0] first_q, second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= 9'd128;
      mode_q   <= MODE_NORMAL;
      first_q  <= MaxCnt;
      second_q <= MaxCnt;
    end else if (cfg_we_i) begin
      case (pbm_cfg_e'(cfg_idx_i))
        CFG_FACTOR:    factor_q <= cfg_data_i;
        CFG_MODE:      mode_q   <= pbm_mode_e'(cfg_data_i[1:0]);
        CFG_FIRST_CH:  first_q  <= cfg_data_i[CntW-1:0];
        CFG_SECOND_CH: second_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] na, nb, nout;
  logic [FacW-1:0] fs;

  assign na   = clamp_cnt(first_q);
  assign nb   = clamp_cnt(second_q);
  assign nout = (na > nb) ? na : nb;
  assign fs   = (factor_q > FacOne) ? FacOne : factor_q;

  // pipeline control
  logic v1_q, v2_q, en1, en2, en3;

  assign en3 = !out_valid_o || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  pbm_lane_ctl_t ctl;
  assign ctl.en1  = en1 && in_valid_i;
  assign ctl.en2  = en2 && v1_q;
  assign ctl.fs   = fs;
  assign ctl.kf   = FacOne - fs;
  assign ctl.mode = mode_q;

  logic [NumLanes-1:0][ChW-1:0] a_raw, b_raw, a_sel, b_sel, res;

  assign a_raw = {a_ch3_i, a_ch2_i, a_ch1_i, a_ch0_i};
  assign b_raw = {b_ch3_i, b_ch2_i, b_ch1_i, b_ch0_i};

  for (genvar c = 0; c < NumLanes; c++) begin : g_lane
    assign a_sel[c] = (CntW'(c) < na) ? a_raw[c] : 8'hFF;
    assign b_sel[c] = (CntW'(c) < nb) ? b_raw[c] : 8'hFF;

    pbm_lane u_lane (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .a_i   (a_sel[c]),
      .b_i   (b_sel[c]),
      .res_o (res[c])
    );
  end

  logic [NumLanes-1:0][ChW-1:0] blend_pix;

  pbm_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2_q),
    .nout_i  (nout),
    .res_i   (res),
    .valid_o (out_valid_o),
    .data_o  (blend_pix)
  );

  assign out_ch0_o = blend_pix[0];
  assign out_ch1_o = blend_pix[1];
  assign out_ch2_o = blend_pix[2];
  assign out_ch3_o = blend_pix[3];

endmodule

`default_nettype wire

// File: rtl/pbm_checker.sv
// Port-level checks for the pixel blender, bound to the top level.
`default_nettype none

module pbm_checker
  import pbm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                cfg_we_i,
  input wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input wire logic [CfgDataW-1:0] cfg_data_i,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic [7:0]          a_ch0_i,
  input wire logic [7:0]          a_ch1_i,
  input wire logic [7:0]          a_ch2_i,
  input wire logic [7:0]          a_ch3_i,
  input wire logic [7:0]          b_ch0_i,
  input wire logic [7:0]          b_ch1_i,
  input wire logic [7:0]          b_ch2_i,
  input wire logic [7:0]          b_ch3_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [7:0]          out_ch0_o,
  input wire logic [7:0]          out_ch1_o,
  input wire logic [7:0]          out_ch2_o,
  input wire logic [7:0]          out_ch3_o
);

  // input backs up only behind a stalled output beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with output free");

  // nothing leaves in the first cycle out of reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("output beat straight out of reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_ch0_o) && $stable(out_ch1_o) &&
       $stable(out_ch2_o) && $stable(out_ch3_o)))
    else $error("stalled output beat changed");

endmodule

bind pixel_blend_modes pbm_checker u_pbm_checker (.*);

`default_nettype wire
